/* hdl/calhq_pkg.sv */
package calhq_pkg;

  localparam int HOT_ENTRIES  = 16;
  localparam int DEAD_ENTRIES = 16;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_CHECK_EN  = 2'd0;
  localparam logic [1:0] REG_CHARGE_LO = 2'd1;
  localparam logic [1:0] REG_TIME_LO   = 2'd2;
  localparam logic [1:0] REG_TIME_HI   = 2'd3;

  localparam logic [4:0]  CHECK_EN_RESET  = 5'd0;
  localparam logic [11:0] CHARGE_LO_RESET = 12'd0;
  localparam logic [7:0]  TIME_LO_RESET   = 8'd0;
  localparam logic [7:0]  TIME_HI_RESET   = 8'd60;

  localparam int EN_LOW  = 0;
  localparam int EN_SAT  = 1;
  localparam int EN_TIME = 2;
  localparam int EN_HOT  = 3;
  localparam int EN_DEAD = 4;

  localparam logic [1:0] RANGE_LOW = 2'd0;
  localparam logic [1:0] RANGE_SAT = 2'd3;

  localparam logic [2:0] OPC_FILTER   = 3'd0;
  localparam logic [2:0] OPC_ADD_HOT  = 3'd1;
  localparam logic [2:0] OPC_REM_HOT  = 3'd2;
  localparam logic [2:0] OPC_ADD_DEAD = 3'd3;
  localparam logic [2:0] OPC_REM_DEAD = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef enum logic [2:0] {
    OPK_NONE,
    OPK_FILTER,
    OPK_ADD_HOT,
    OPK_REM_HOT,
    OPK_ADD_DEAD,
    OPK_REM_DEAD
  } op_kind_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] crystal_id;
    logic [1:0]  charge_range;
    logic [11:0] charge;
    logic [7:0]  hit_time;
  } hit_t;

  typedef struct packed {
    logic       hit_good;
    logic [1:0] op_status;
  } res_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [31:0] crystal_id;
    logic        scalar_ok;
    logic        hot_chk;
    logic        dead_chk;
  } entry_t;

  typedef struct packed {
    logic        en;
    op_kind_t    kind;
    logic [31:0] crystal_id;
  } tbl_cmd_t;

  typedef struct packed {
    logic hot_found;
    logic hot_full;
    logic dead_found;
    logic dead_full;
  } tbl_stat_t;

endpackage

/* hdl/calhq_front.sv */
module calhq_front
  import calhq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  input  logic              hit_valid,
  output logic              hit_stall,
  input  hit_t              hit_data,
  input  logic              q_full,
  output logic              q_push,
  output entry_t            q_entry
);

  logic [4:0]  check_en;
  logic [11:0] charge_lo;
  logic [7:0]  time_lo;
  logic [7:0]  time_hi;
  logic        wr;
  logic [1:0]  reg_idx;
  logic        low_fail;
  logic        sat_fail;
  logic        time_fail;
  op_kind_t    kind;

  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      check_en  <= CHECK_EN_RESET;
      charge_lo <= CHARGE_LO_RESET;
      time_lo   <= TIME_LO_RESET;
      time_hi   <= TIME_HI_RESET;
    end else if (wr) begin
      unique case (reg_idx)
        REG_CHECK_EN:  check_en  <= pwdata[4:0];
        REG_CHARGE_LO: charge_lo <= pwdata[11:0];
        REG_TIME_LO:   time_lo   <= pwdata[7:0];
        REG_TIME_HI:   time_hi   <= pwdata[7:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CHECK_EN:  prdata = {27'd0, check_en};
      REG_CHARGE_LO: prdata = {20'd0, charge_lo};
      REG_TIME_LO:   prdata = {24'd0, time_lo};
      REG_TIME_HI:   prdata = {24'd0, time_hi};
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    unique case (hit_data.opcode)
      OPC_FILTER:   kind = OPK_FILTER;
      OPC_ADD_HOT:  kind = OPK_ADD_HOT;
      OPC_REM_HOT:  kind = OPK_REM_HOT;
      OPC_ADD_DEAD: kind = OPK_ADD_DEAD;
      OPC_REM_DEAD: kind = OPK_REM_DEAD;
      default:      kind = OPK_NONE;
    endcase
  end

  assign low_fail  = check_en[EN_LOW] && (hit_data.charge_range == RANGE_LOW)
                     && (hit_data.charge < charge_lo);
  assign sat_fail  = check_en[EN_SAT] && (hit_data.charge_range == RANGE_SAT);
  assign time_fail = check_en[EN_TIME]
                     && ((hit_data.hit_time < time_lo) || (hit_data.hit_time > time_hi));

  assign hit_stall = q_full;
  assign q_push    = hit_valid && !q_full;

  always_comb begin
    q_entry.kind       = kind;
    q_entry.crystal_id = hit_data.crystal_id;
    q_entry.scalar_ok  = !(low_fail || sat_fail || time_fail);
    q_entry.hot_chk    = check_en[EN_HOT];
    q_entry.dead_chk   = check_en[EN_DEAD];
  end

endmodule

/* hdl/calhq_queue.sv */
module calhq_queue
  import calhq_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

/* hdl/calhq_tables.sv */
module calhq_tables
  import calhq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  tbl_cmd_t  cmd,
  output tbl_stat_t stat
);

  logic [31:0]             hot_ids   [HOT_ENTRIES];
  logic [HOT_ENTRIES-1:0]  hot_valid;
  logic [HOT_ENTRIES-1:0]  hot_match;
  logic [HOT_ENTRIES-1:0]  hot_free;
  logic [HOT_ENTRIES-1:0]  hot_first;
  logic [31:0]             dead_ids  [DEAD_ENTRIES];
  logic [DEAD_ENTRIES-1:0] dead_valid;
  logic [DEAD_ENTRIES-1:0] dead_match;
  logic [DEAD_ENTRIES-1:0] dead_free;
  logic [DEAD_ENTRIES-1:0] dead_first;
  logic                    hot_add;
  logic                    hot_rem;
  logic                    dead_add;
  logic                    dead_rem;

  always_comb begin
    for (int i = 0; i < HOT_ENTRIES; i++) begin
      hot_match[i] = hot_valid[i] && (hot_ids[i] == cmd.crystal_id);
    end
    for (int i = 0; i < DEAD_ENTRIES; i++) begin
      dead_match[i] = dead_valid[i] && (dead_ids[i] == cmd.crystal_id);
    end
  end

  assign hot_free   = ~hot_valid;
  assign hot_first  = hot_free & (~hot_free + HOT_ENTRIES'(1));
  assign dead_free  = ~dead_valid;
  assign dead_first = dead_free & (~dead_free + DEAD_ENTRIES'(1));

  assign stat.hot_found  = |hot_match;
  assign stat.hot_full   = ~|hot_free;
  assign stat.dead_found = |dead_match;
  assign stat.dead_full  = ~|dead_free;

  assign hot_add  = cmd.en && (cmd.kind == OPK_ADD_HOT) && !stat.hot_found;
  assign hot_rem  = cmd.en && (cmd.kind == OPK_REM_HOT);
  assign dead_add = cmd.en && (cmd.kind == OPK_ADD_DEAD) && !stat.dead_found;
  assign dead_rem = cmd.en && (cmd.kind == OPK_REM_DEAD);

  always_ff @(posedge clk) begin
    for (int i = 0; i < HOT_ENTRIES; i++) begin
      if (hot_add && hot_first[i]) begin
        hot_ids[i] <= cmd.crystal_id;
      end
    end
    for (int i = 0; i < DEAD_ENTRIES; i++) begin
      if (dead_add && dead_first[i]) begin
        dead_ids[i] <= cmd.crystal_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hot_valid  <= '0;
      dead_valid <= '0;
    end else begin
      if (hot_add) begin
        hot_valid <= hot_valid | hot_first;
      end else if (hot_rem) begin
        hot_valid <= hot_valid & ~hot_match;
      end
      if (dead_add) begin
        dead_valid <= dead_valid | dead_first;
      end else if (dead_rem) begin
        dead_valid <= dead_valid & ~dead_match;
      end
    end
  end

endmodule

/* hdl/calhq_back.sv */
module calhq_back
  import calhq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  entry_t    head,
  input  logic      q_empty,
  output logic      q_pop,
  output tbl_cmd_t  tbl_cmd,
  input  tbl_stat_t tbl_stat,
  output logic      res_valid,
  input  logic      res_stall,
  output res_t      res_data
);

  res_t res_next;

  assign q_pop = !q_empty && (!res_valid || !res_stall);

  always_comb begin
    tbl_cmd.en         = q_pop;
    tbl_cmd.kind       = head.kind;
    tbl_cmd.crystal_id = head.crystal_id;
  end

  always_comb begin
    res_next = '0;
    unique case (head.kind)
      OPK_FILTER: begin
        res_next.hit_good = head.scalar_ok
                            && !(head.hot_chk && tbl_stat.hot_found)
                            && !(head.dead_chk && tbl_stat.dead_found);
      end
      OPK_ADD_HOT: begin
        if (!tbl_stat.hot_found && tbl_stat.hot_full) begin
          res_next.op_status = ST_FULL;
        end
      end
      OPK_ADD_DEAD: begin
        if (!tbl_stat.dead_found && tbl_stat.dead_full) begin
          res_next.op_status = ST_FULL;
        end
      end
      OPK_REM_HOT: begin
        if (!tbl_stat.hot_found) begin
          res_next.op_status = ST_NOT_FOUND;
        end
      end
      OPK_REM_DEAD: begin
        if (!tbl_stat.dead_found) begin
          res_next.op_status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_data <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (q_pop) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

endmodule

/* hdl/calorimeter_hit_qualifier_top.sv */
// Calorimeter hit qualifier. Each accepted item (a hit to filter or a hot/dead
// mask table edit) yields exactly one result item, in order. A front stage
// classifies the item and applies the charge and time checks, a two-entry queue
// decouples it from the back stage, which compares the id against all sixteen
// slots of both mask tables at once, edits the tables and registers the result.
// One item per cycle is sustained while the result side does not stall. Registers
// lie at byte addresses 0x0 check enables, 0x4 charge low threshold, 0x8 time
// low limit, 0xC time high limit; the user must write them only while no item is
// in flight, which the block itself does not enforce.
module calorimeter_hit_qualifier_top
  import calhq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              hit_valid,
  output logic              hit_stall,
  input  hit_t              hit_data,
  output logic              res_valid,
  input  logic              res_stall,
  output res_t              res_data
);

  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;
  entry_t    q_entry;
  entry_t    q_head;
  tbl_cmd_t  tbl_cmd;
  tbl_stat_t tbl_stat;

  assign pready = 1'b1;

  calhq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .hit_valid (hit_valid),
    .hit_stall (hit_stall),
    .hit_data  (hit_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  calhq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_entry),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  calhq_tables u_tables (
    .clk  (clk),
    .rst  (rst),
    .cmd  (tbl_cmd),
    .stat (tbl_stat)
  );

  calhq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .tbl_cmd   (tbl_cmd),
    .tbl_stat  (tbl_stat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

/* hdl/calhq_checker.sv */
module calhq_checker
  import calhq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic pready,
  input logic res_valid,
  input logic res_stall,
  input res_t res_data
);

  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("held result changed");

  assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result after reset");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_data.hit_good && res_data.op_status != ST_OK))
    else $error("good hit with status");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.op_status == ST_OK || res_data.op_status == ST_NOT_FOUND
                   || res_data.op_status == ST_FULL))
    else $error("bad status code");

  assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind calorimeter_hit_qualifier_top calhq_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .pready    (pready),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);
